FILE: sv/rmdw_pkg.sv
`timescale 1ns / 1ps

package rmdw_pkg;

  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int CHANNELS    = 2;
  localparam int IO_CHANNELS = 2;
  localparam int CH_BITS     = (IO_CHANNELS > 1) ? $clog2(IO_CHANNELS) : 1;

  localparam int PHASE_BITS   = 32;
  localparam int CARRIER_BITS = 24;
  localparam int WET_BITS     = 17;
  localparam int GAIN_BITS    = 25;
  localparam int SUM_BITS     = 42;
  localparam int ENABLE_BITS  = 2;
  localparam int USER_BITS    = 3;
  localparam int ENABLE_LSB   = 0;
  localparam int RESTART_BIT  = 2;

  localparam logic [WET_BITS-1:0] WET_ONE = 17'd65536;

  localparam logic [63:0] HALF_PI_Q30        = 64'd1686629713;
  localparam logic signed [63:0] CARRIER_MAX = 64'sd8388607;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_PHASE_STEP = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WET_GAIN   = 1'd1;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_step;
    logic [WET_BITS-1:0]   wet_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROM,
    B_WMUL,
    B_GAIN,
    B_MUL,
    B_SAT,
    B_OUT
  } back_state_t;

endpackage

FILE: sv/rmdw_front.sv
`timescale 1ns / 1ps

module rmdw_front #(
  parameter int SAMPLE_BITS = rmdw_pkg::SAMPLE_BITS_DEF,
  parameter int DATA_W      = 48,
  parameter int ENTRY_W     = 82
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rmdw_pkg::cfg_t                cfg,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [DATA_W-1:0]             s_axis_tdata,
  input  logic [rmdw_pkg::USER_BITS-1:0] s_axis_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [ENTRY_W-1:0]            q_din
);

  logic [rmdw_pkg::PHASE_BITS-1:0] carrier_phase;
  logic [rmdw_pkg::PHASE_BITS-1:0] phase_use;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;
  assign phase_use     = s_axis_tuser[rmdw_pkg::RESTART_BIT] ? '0 : carrier_phase;
  assign q_din         = {phase_use,
                          s_axis_tuser[rmdw_pkg::ENABLE_LSB +: rmdw_pkg::ENABLE_BITS],
                          s_axis_tdata[2*SAMPLE_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
    end else if (q_push) begin
      carrier_phase <= phase_use + cfg.phase_step;
    end
  end

endmodule

FILE: sv/rmdw_queue.sv
`timescale 1ns / 1ps

module rmdw_queue #(
  parameter int ENTRY_W = 82
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [ENTRY_W-1:0] din,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output logic [ENTRY_W-1:0] dout
);

  localparam int PTR_W = $clog2(rmdw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rmdw_pkg::QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] slots [rmdw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(rmdw_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign dout     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(rmdw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(rmdw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/rmdw_back.sv
`timescale 1ns / 1ps

module rmdw_back #(
  parameter int SAMPLE_BITS     = rmdw_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = rmdw_pkg::SINE_TABLE_BITS_DEF,
  parameter int DATA_W          = 48,
  parameter int ENTRY_W         = 82
) (
  input  logic               clk,
  input  logic               rst,
  input  rmdw_pkg::cfg_t     cfg,
  input  logic               q_nonempty,
  input  logic [ENTRY_W-1:0] q_dout,
  output logic               q_pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata
);

  localparam int N       = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W  = SINE_TABLE_BITS + 1;
  localparam int ROM_W   = rmdw_pkg::CARRIER_BITS - 1;
  localparam int MA_W    = (SAMPLE_BITS > rmdw_pkg::WET_BITS + 1) ?
                           SAMPLE_BITS : rmdw_pkg::WET_BITS + 1;
  localparam int MB_W    = rmdw_pkg::GAIN_BITS;
  localparam int MP_W    = MA_W + MB_W;
  localparam int PROD_W  = SAMPLE_BITS + rmdw_pkg::GAIN_BITS;
  localparam int R_W     = PROD_W - 23;
  localparam int PHASE_W = rmdw_pkg::PHASE_BITS;
  localparam int SUM_W   = rmdw_pkg::SUM_BITS;

  typedef logic [ROM_W-1:0] rom_t [0:N];

  function automatic rom_t build_sine();
    rom_t               t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    for (int k = 0; k <= N; k++) begin
      x    = (64'(k) * rmdw_pkg::HALF_PI_Q30) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      q = (sum + 64'sd64) >>> 7;
      if (q < 0) begin
        q = '0;
      end
      if (q > rmdw_pkg::CARRIER_MAX || k == N) begin
        q = rmdw_pkg::CARRIER_MAX;
      end
      t[k] = q[ROM_W-1:0];
    end
    return t;
  endfunction

  localparam rom_t SINE = build_sine();

  rmdw_pkg::back_state_t state, state_next;

  logic                              load;
  logic [rmdw_pkg::CH_BITS-1:0]      ch;
  logic [PHASE_W-1:0]                phase_r;
  logic [rmdw_pkg::ENABLE_BITS-1:0]  en_r;
  logic [SAMPLE_BITS-1:0]            samp [rmdw_pkg::IO_CHANNELS];
  logic [SAMPLE_BITS-1:0]            res  [rmdw_pkg::IO_CHANNELS];
  logic [ROM_W-1:0]                  rom_q;
  logic [ADDR_W-1:0]                 rom_addr;
  logic [SINE_TABLE_BITS-1:0]        k_idx;
  logic signed [rmdw_pkg::CARRIER_BITS-1:0] carrier;
  logic signed [MA_W-1:0]            mul_a;
  logic signed [MB_W-1:0]            mul_b;
  logic signed [MP_W-1:0]            mul_q;
  logic signed [MB_W-1:0]            gain;
  logic signed [SUM_W-1:0]           gain_sum;
  logic [rmdw_pkg::WET_BITS-1:0]     dry;
  logic signed [PROD_W-1:0]          prod;
  logic signed [PROD_W-1:0]          prod_rnd;
  logic signed [R_W-1:0]             rounded;
  logic [SAMPLE_BITS-1:0]            sat_val;
  logic                              ch_on;

  localparam logic signed [R_W-1:0] HI = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [R_W-1:0] LO = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

  // carrier lookup
  assign k_idx    = phase_r[PHASE_W-3 -: SINE_TABLE_BITS];
  assign rom_addr = phase_r[PHASE_W-2] ? (ADDR_W'(N) - {1'b0, k_idx}) : {1'b0, k_idx};
  assign carrier  = phase_r[PHASE_W-1] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_ff @(posedge clk) begin
    rom_q <= SINE[rom_addr];
  end

  // shared multiplier
  always_comb begin
    if (state == rmdw_pkg::B_WMUL) begin
      mul_a = MA_W'($signed({1'b0, cfg.wet_gain}));
      mul_b = MB_W'(carrier);
    end else begin
      mul_a = MA_W'($signed(samp[ch]));
      mul_b = gain;
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= MP_W'(mul_a) * MP_W'(mul_b);
  end

  // gain and rounding
  assign dry      = rmdw_pkg::WET_ONE - cfg.wet_gain;
  assign gain_sum = SUM_W'($signed({1'b0, dry, 23'b0})) + $signed(mul_q[SUM_W-1:0])
                    + SUM_W'(32768);
  assign prod     = $signed(mul_q[PROD_W-1:0]);
  assign prod_rnd = prod + PROD_W'(1 << 22);
  assign rounded  = prod_rnd[PROD_W-1:23];
  assign ch_on    = en_r[ch] && (32'(ch) < rmdw_pkg::CHANNELS);

  always_comb begin
    if (rounded > HI) begin
      sat_val = HI[SAMPLE_BITS-1:0];
    end else if (rounded < LO) begin
      sat_val = LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = rounded[SAMPLE_BITS-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmdw_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    case (state)
      rmdw_pkg::B_IDLE: begin
        if (q_nonempty) begin
          q_pop      = 1'b1;
          state_next = rmdw_pkg::B_ROM;
        end
      end
      rmdw_pkg::B_ROM:  state_next = rmdw_pkg::B_WMUL;
      rmdw_pkg::B_WMUL: state_next = rmdw_pkg::B_GAIN;
      rmdw_pkg::B_GAIN: state_next = rmdw_pkg::B_MUL;
      rmdw_pkg::B_MUL:  state_next = rmdw_pkg::B_SAT;
      rmdw_pkg::B_SAT: begin
        if (ch == rmdw_pkg::CH_BITS'(rmdw_pkg::IO_CHANNELS - 1)) begin
          state_next = rmdw_pkg::B_OUT;
        end else begin
          state_next = rmdw_pkg::B_MUL;
        end
      end
      rmdw_pkg::B_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load = 1'b1;
          if (q_nonempty) begin
            q_pop      = 1'b1;
            state_next = rmdw_pkg::B_ROM;
          end else begin
            state_next = rmdw_pkg::B_IDLE;
          end
        end
      end
      default: state_next = rmdw_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      phase_r <= q_dout[ENTRY_W-1 -: PHASE_W];
      en_r    <= q_dout[2*SAMPLE_BITS +: rmdw_pkg::ENABLE_BITS];
      for (int i = 0; i < rmdw_pkg::IO_CHANNELS; i++) begin
        samp[i] <= q_dout[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    if (state == rmdw_pkg::B_GAIN) begin
      gain <= gain_sum[SUM_W-2:16];
    end
    if (state == rmdw_pkg::B_SAT) begin
      res[ch] <= ch_on ? sat_val : samp[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (q_pop) begin
      ch <= '0;
    end else if (state == rmdw_pkg::B_SAT) begin
      ch <= ch + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= DATA_W'({res[1], res[0]});
    end
  end

endmodule

FILE: sv/ring_modulator_dry_wet.sv
`timescale 1ns / 1ps
// Stereo ring modulator with dry/wet mix.
// Input stream s_axis: tdata = left_sample, right_sample (signed, SAMPLE_BITS each),
//   tuser = channel_enable[1:0], phase_restart[2]. A clear enable bit passes that
//   channel through unchanged; phase_restart zeroes the carrier phase for this item.
// Output stream m_axis: tdata = left_result, right_result, saturated.
// Config channel cfg_valid/cfg_ready/cfg_addr/cfg_data, always ready:
//   index 0 phase_step (phase added after each item), index 1 wet_gain (Q1.16,
//   values above 65536 clamp to 65536). Write only while no item is in flight.
// The back-end sequencer runs the sine lookup, gain and both channels through one
//   shared multiplier, and takes a new item only once the last one has reached OUT.
// Path to m_axis_tvalid: queue, then states ROM, WMUL, GAIN, MUL/SAT per channel, OUT.
// A 2-entry queue separates the input side from the sequencer. While m_axis_tready
//   is low, up to four items are held (output register, sequencer, two queue
//   entries); s_axis_tready then drops until the output drains.
// Reset (rst, synchronous) clears the carrier phase, sets phase_step to 0 and
//   wet_gain to 65536, and empties the queue and output register.
module ring_modulator_dry_wet #(
  parameter int SAMPLE_BITS     = rmdw_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = rmdw_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // left_sample, right_sample, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // channel_enable[1:0], phase_restart[2]
  input  logic [rmdw_pkg::USER_BITS-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // left_result, right_result, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rmdw_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [rmdw_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int DATA_W  = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int ENTRY_W = rmdw_pkg::PHASE_BITS + rmdw_pkg::ENABLE_BITS + 2*SAMPLE_BITS;

  rmdw_pkg::cfg_t cfg;
  logic [rmdw_pkg::WET_BITS-1:0] wet_in;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_nonempty;
  logic [ENTRY_W-1:0] q_din;
  logic [ENTRY_W-1:0] q_dout;

  assign cfg_ready = 1'b1;
  assign wet_in    = cfg_data[rmdw_pkg::WET_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= '0;
      cfg.wet_gain   <= rmdw_pkg::WET_ONE;
    end else if (cfg_valid) begin
      if (cfg_addr == rmdw_pkg::CFG_PHASE_STEP) begin
        cfg.phase_step <= cfg_data[rmdw_pkg::PHASE_BITS-1:0];
      end else if (cfg_addr == rmdw_pkg::CFG_WET_GAIN) begin
        cfg.wet_gain <= (wet_in > rmdw_pkg::WET_ONE) ? rmdw_pkg::WET_ONE : wet_in;
      end
    end
  end

  rmdw_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DATA_W      (DATA_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_din         (q_din)
  );

  rmdw_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .din      (q_din),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (q_dout)
  );

  rmdw_back #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .DATA_W          (DATA_W),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_nonempty    (q_nonempty),
    .q_dout        (q_dout),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: sv/rmdw_checker.sv
`timescale 1ns / 1ps

module rmdw_checker #(
  parameter int SAMPLE_BITS = rmdw_pkg::SAMPLE_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(s_axis_tvalid && s_axis_tready)
                         - 3'(m_axis_tvalid && m_axis_tready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 3'd0)
    else $error("output item without a pending input item");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd4 |-> !s_axis_tready)
    else $error("input accepted beyond queue capacity");

endmodule

bind ring_modulator_dry_wet rmdw_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/rmdw_monitor.sv
`timescale 1ns / 1ps

module rmdw_monitor #(
  parameter int SAMPLE_BITS     = rmdw_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = rmdw_pkg::SINE_TABLE_BITS_DEF,
  parameter int DATA_W          = ((2*SAMPLE_BITS+7)/8)*8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  // left_sample, right_sample, zero pad
  input  logic [DATA_W-1:0]                  s_axis_tdata,
  // channel_enable[1:0], phase_restart[2]
  input  logic [rmdw_pkg::USER_BITS-1:0]     s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // left_result, right_result, zero pad
  input  logic [DATA_W-1:0]                  m_axis_tdata,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [rmdw_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [rmdw_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                 outstanding,
  output int                                 fail_count
);

  localparam int     TAB_N  = 1 << SINE_TABLE_BITS;
  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
  } stereo_t;

  longint             sine_q [0:TAB_N];
  logic [31:0]        carrier_phase;
  logic [31:0]        phase_step;
  logic [rmdw_pkg::WET_BITS-1:0] wet_gain;
  stereo_t            expected_mix_q [$];
  int                 result_idx;

  initial begin : build_sine
    longint unsigned x, x2, term;
    longint          sum, q;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'(k) * rmdw_pkg::HALF_PI_Q30) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2*n) * (2*n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      q = (sum + 64) >>> 7;
      if (q < 0) q = 0;
      if (q > rmdw_pkg::CARRIER_MAX || k == TAB_N) q = rmdw_pkg::CARRIER_MAX;
      sine_q[k] = q;
    end
  end

  function automatic longint carrier_of(logic [31:0] ph);
    logic [1:0]  quad;
    int unsigned k;
    longint      v;
    quad = ph[31:30];
    k    = (ph >> (30 - SINE_TABLE_BITS)) & (TAB_N - 1);
    v    = quad[0] ? sine_q[TAB_N - k] : sine_q[k];
    return quad[1] ? -v : v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
    logic signed [SAMPLE_BITS-1:0] smp, longint g);
    longint s, r;
    s = smp;
    r = (s * g + (longint'(1) <<< 22)) >>> 23;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[SAMPLE_BITS-1:0];
  endfunction

  task automatic predict_mix(input logic [DATA_W-1:0] data,
                             input logic [rmdw_pkg::USER_BITS-1:0] user);
    stereo_t                          exp_item;
    logic [rmdw_pkg::ENABLE_BITS-1:0] en;
    longint                           c, w, g;
    en = user[rmdw_pkg::ENABLE_LSB +: rmdw_pkg::ENABLE_BITS];
    if (user[rmdw_pkg::RESTART_BIT]) carrier_phase = '0;
    c = carrier_of(carrier_phase);
    w = wet_gain;
    g = (65536 - w) * (longint'(1) <<< 23) + w * c;
    g = (g + 32768) >>> 16;
    exp_item.left  = data[SAMPLE_BITS-1:0];
    exp_item.right = data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    if (en[0]) exp_item.left = scale_sample(exp_item.left, g);
    if (en[1]) exp_item.right = scale_sample(exp_item.right, g);
    expected_mix_q.push_back(exp_item);
    carrier_phase = carrier_phase + phase_step;
  endtask

  task automatic report(input string what, input logic [SAMPLE_BITS-1:0] exp_v,
                        input logic [SAMPLE_BITS-1:0] got_v);
    if (fail_count < 10)
      $display("result %0d %s: expected %h got %h", result_idx, what, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    stereo_t          exp_item;
    stereo_t          got_item;
    logic [rmdw_pkg::WET_BITS-1:0] w;
    if (rst) begin
      carrier_phase = '0;
      phase_step    = '0;
      wet_gain      = rmdw_pkg::WET_ONE;
      fail_count    = 0;
      result_idx    = 0;
      expected_mix_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == rmdw_pkg::CFG_PHASE_STEP) begin
          phase_step = cfg_data[31:0];
        end else if (cfg_addr == rmdw_pkg::CFG_WET_GAIN) begin
          w        = cfg_data[rmdw_pkg::WET_BITS-1:0];
          wet_gain = (w > rmdw_pkg::WET_ONE) ? rmdw_pkg::WET_ONE : w;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_item.left  = m_axis_tdata[SAMPLE_BITS-1:0];
        got_item.right = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (expected_mix_q.size() == 0) begin
          if (fail_count < 10)
            $display("result %0d: item with nothing expected, data %h",
                     result_idx, m_axis_tdata);
          fail_count++;
        end else begin
          exp_item = expected_mix_q.pop_front();
          if (got_item.left !== exp_item.left)
            report("left", exp_item.left, got_item.left);
          if (got_item.right !== exp_item.right)
            report("right", exp_item.right, got_item.right);
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) predict_mix(s_axis_tdata, s_axis_tuser);
    end
    outstanding = expected_mix_q.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SB        = rmdw_pkg::SAMPLE_BITS_DEF;
  localparam int DATA_W    = ((2*SB+7)/8)*8;
  localparam int CYCLE_CAP = 1200000;
  localparam int PHASES    = 8;
  localparam int PER_PHASE = 236;

  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                               clk;
  logic                               rst;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [DATA_W-1:0]                  s_axis_tdata;
  logic [rmdw_pkg::USER_BITS-1:0]     s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [DATA_W-1:0]                  m_axis_tdata;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [rmdw_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
  logic [rmdw_pkg::CFG_DATA_BITS-1:0] cfg_data;
  int                                 outstanding;
  int                                 fail_count;
  int                                 cycles = 0;
  bit                                 no_gaps;

  ring_modulator_dry_wet u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  rmdw_monitor u_monitor (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("ring_modulator_dry_wet: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return S_MAX;
    if (r == 1) return S_MIN;
    if (r == 2) return SB'($signed($urandom_range(0, 512)) - 256);
    return SB'($urandom);
  endfunction

  // receiver side: random stalls on m_axis_tready
  initial begin : sink
    int hold;
    int gap;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          hold = gap - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_frame(input logic [SB-1:0] left, input logic [SB-1:0] right,
                            input logic [rmdw_pkg::ENABLE_BITS-1:0] en,
                            input logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'({right, left});
    s_axis_tuser  <= {restart, en};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // hold off input until every expected item has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic program_regs(input logic [31:0] step, input logic [31:0] wet);
    cfg_valid <= 1'b1;
    cfg_addr  <= rmdw_pkg::CFG_PHASE_STEP;
    cfg_data  <= step;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_addr  <= rmdw_pkg::CFG_WET_GAIN;
    cfg_data  <= wet;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0]                      step;
    logic [31:0]                      wet;
    logic [rmdw_pkg::ENABLE_BITS-1:0] en;
    rst           = 1'b1;
    no_gaps       = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_addr      = rmdw_pkg::CFG_PHASE_STEP;
    cfg_data      = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: carrier sits at zero
    send_frame(S_MAX, S_MIN, 2'b11, 1'b0);
    send_frame(S_MIN, S_MAX, 2'b00, 1'b0);
    send_frame('1, SB'(1), 2'b01, 1'b1);
    send_frame('0, '1, 2'b10, 1'b0);
    wait_idle();

    // quarter-turn step walks zero, peak, zero, trough; wet write clamps
    program_regs(32'h4000_0000, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++)
      send_frame(i[0] ? S_MIN : S_MAX, i[1] ? S_MIN : S_MAX, 2'b11, i == 0);
    wait_idle();

    // dry only, then half mix stepping backwards
    program_regs(32'h4000_0000, 32'd0);
    send_frame(S_MIN, S_MAX, 2'b11, 1'b1);
    send_frame(S_MAX, S_MIN, 2'b01, 1'b0);
    send_frame(S_MIN, S_MIN, 2'b10, 1'b0);
    wait_idle();
    program_regs(32'hFFFF_FFFF, 32'd32768);
    send_frame(S_MIN, S_MIN, 2'b11, 1'b1);
    send_frame(S_MAX, S_MAX, 2'b11, 1'b0);
    send_frame(pick_sample(), pick_sample(), 2'b11, 1'b0);
    send_frame(SB'(1), '1, 2'b11, 1'b1);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin step = 32'h0000_0000; wet = 32'd65536; end
        1: begin step = $urandom;      wet = 32'd0;     end
        2: begin step = 32'hFFFF_FFFF; wet = 32'd32768; end
        3: begin step = 32'h0010_0000; wet = 32'd65535; end
        4: begin step = $urandom;      wet = $urandom_range(0, 32'h1FFFF); end
        5: begin step = $urandom_range(1, 1 << 20); wet = $urandom; end
        6: begin step = 32'h8000_0000; wet = 32'd1;     end
        default: begin step = $urandom; wet = 32'h0001_FFFF; end
      endcase
      program_regs(step, wet);
      for (int i = 0; i < PER_PHASE; i++) begin
        no_gaps = (ph == 2) || (i >= 100 && i < 130);
        en = ($urandom_range(0, 9) < 6) ? 2'b11 : rmdw_pkg::ENABLE_BITS'($urandom);
        send_frame(pick_sample(), pick_sample(), en, $urandom_range(0, 15) == 0);
        if (ph == 4 && i == 150) wait_idle();
      end
      no_gaps = 1'b0;
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ring_modulator_dry_wet: match");
    end else begin
      $display("ring_modulator_dry_wet: mismatch");
    end
    $finish;
  end

endmodule
